FILE: src/bsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap slot allocator package
// Sizes, field widths and command codes shared by the allocator files.
// ----------------------------------------------------------------------------
package bsa_pkg;

  // Slot space and word geometry.
  localparam int MAX_SLOTS  = 1024;
  localparam int WORD_BITS  = 32;
  localparam int NUM_WORDS  = MAX_SLOTS / WORD_BITS;
  localparam int BIT_IDX_W  = $clog2(WORD_BITS);
  localparam int WORD_IDX_W = $clog2(NUM_WORDS);
  localparam int SLOT_IDX_W = WORD_IDX_W + BIT_IDX_W;

  // Field widths of the command and configuration ports.
  localparam int CMD_W = 2;
  localparam int ACT_W = 6;

  // Reset value of the active word count.
  localparam logic [ACT_W-1:0] ACT_WORDS_RESET = ACT_W'(32);

  // Command codes.
  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_SET     = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_PROBE   = 2'd3
  } cmd_t;

endpackage

FILE: src/bitmap_slot_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap slot allocator core
// Allocates, claims, releases and probes slots held in a word-wide bitmap RAM.
// ----------------------------------------------------------------------------
// Usage:
//   A command word (cmd, entry_index) is taken at a rising edge where start is
//   high and busy is low. Allocate ignores entry_index and returns the lowest
//   free slot at or above the first-free word hint; set, release and probe act
//   on the named slot.
//   Each command yields exactly one result word, shown on status,
//   allocated_index and slot_taken for one cycle while done is high. The
//   receiver cannot stall; the result must be taken in that cycle.
//   A new command is taken only once the last one is through. The bitmap RAM
//   read comes first (the word is picked from the per-word full flags), then
//   the modify and write-back, which also updates the full flags and the hint.
//   The active word count is written through cfg_wr_en / cfg_wr_data while
//   the core is idle, a rule for the user that the core does not enforce;
//   the write does not touch the bitmap or the hint.
//   Reset (rst, synchronous) empties the bitmap at once through per-word
//   valid bits, zeroes the hint and sets the active word count to 32.
// ----------------------------------------------------------------------------
module bitmap_slot_allocator_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [bsa_pkg::CMD_W-1:0]      cmd,
  input  logic [bsa_pkg::SLOT_IDX_W-1:0] entry_index,
  input  logic                          cfg_wr_en,
  input  logic [bsa_pkg::ACT_W-1:0]      cfg_wr_data,
  output logic                          done,
  output logic                          status,
  output logic [bsa_pkg::SLOT_IDX_W-1:0] allocated_index,
  output logic                          slot_taken
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state;

  // Architectural state outside the RAM.
  logic [bsa_pkg::ACT_W-1:0]      active_words;
  logic [bsa_pkg::WORD_IDX_W-1:0] hint;
  logic [bsa_pkg::NUM_WORDS-1:0]  word_full;
  logic [bsa_pkg::NUM_WORDS-1:0]  word_valid;

  // Command held across the read cycle.
  bsa_pkg::cmd_t                  cmd_q;
  logic [bsa_pkg::WORD_IDX_W-1:0] wi_q;
  logic [bsa_pkg::BIT_IDX_W-1:0]  bit_q;
  logic                           in_range_q;
  logic                           found_q;

  // Index of the lowest set bit of a vector with one bit per word.
  function automatic logic [bsa_pkg::WORD_IDX_W-1:0] low_word(
    input logic [bsa_pkg::NUM_WORDS-1:0] v
  );
    logic [bsa_pkg::WORD_IDX_W-1:0] r;
    r = '0;
    for (int i = bsa_pkg::NUM_WORDS - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = bsa_pkg::WORD_IDX_W'(i);
      end
    end
    return r;
  endfunction

  // Lowest clear bit of a bitmap word.
  function automatic logic [bsa_pkg::BIT_IDX_W-1:0] low_clear(
    input logic [bsa_pkg::WORD_BITS-1:0] w
  );
    logic [bsa_pkg::BIT_IDX_W-1:0] r;
    r = '0;
    for (int i = bsa_pkg::WORD_BITS - 1; i >= 0; i--) begin
      if (!w[i]) begin
        r = bsa_pkg::BIT_IDX_W'(i);
      end
    end
    return r;
  endfunction

  // Active word count clamped to the RAM depth.
  logic [bsa_pkg::ACT_W-1:0] eff_words;
  assign eff_words = (active_words > bsa_pkg::ACT_W'(bsa_pkg::NUM_WORDS)) ?
                     bsa_pkg::ACT_W'(bsa_pkg::NUM_WORDS) : active_words;

  // Decode of the incoming command word.
  logic                           accept;
  logic [bsa_pkg::WORD_IDX_W-1:0] in_wi;
  logic [bsa_pkg::BIT_IDX_W-1:0]  in_bit;
  logic                           in_range;

  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;
  assign in_wi    = entry_index[bsa_pkg::SLOT_IDX_W-1:bsa_pkg::BIT_IDX_W];
  assign in_bit   = entry_index[bsa_pkg::BIT_IDX_W-1:0];
  assign in_range = ({1'b0, in_wi} < eff_words);

  // Candidate words for allocate: not full, at or above the hint, active.
  logic [bsa_pkg::NUM_WORDS-1:0]  cand;
  logic [bsa_pkg::WORD_IDX_W-1:0] cand_wi;

  always_comb begin
    for (int i = 0; i < bsa_pkg::NUM_WORDS; i++) begin
      cand[i] = !word_full[i] &&
                (bsa_pkg::ACT_W'(hint) <= bsa_pkg::ACT_W'(i)) &&
                (bsa_pkg::ACT_W'(i) < eff_words);
    end
    cand_wi = low_word(cand);
  end

  // Bitmap RAM read address: picked word for allocate, named word otherwise.
  logic [bsa_pkg::WORD_IDX_W-1:0] rd_wi;
  assign rd_wi = (bsa_pkg::cmd_t'(cmd) == bsa_pkg::CMD_ALLOC) ? cand_wi : in_wi;

  logic                           ram_we;
  logic [bsa_pkg::WORD_BITS-1:0]  ram_wdata;
  logic [bsa_pkg::WORD_BITS-1:0]  ram_rdata;

  bsa_ram #(
    .WIDTH (bsa_pkg::WORD_BITS),
    .DEPTH (bsa_pkg::NUM_WORDS)
  ) u_bitmap_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wi_q),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (rd_wi),
    .rdata (ram_rdata)
  );

  // Modify step: a word never written since reset reads as empty.
  logic [bsa_pkg::WORD_BITS-1:0]  cur_word;
  logic [bsa_pkg::WORD_BITS-1:0]  bit_mask;
  logic [bsa_pkg::BIT_IDX_W-1:0]  free_bit;
  logic                           cur_bit;
  logic                           status_next;
  logic                           taken_next;
  logic [bsa_pkg::SLOT_IDX_W-1:0] alloc_next;
  logic                           hint_we;

  always_comb begin
    cur_word    = word_valid[wi_q] ? ram_rdata : '0;
    bit_mask    = bsa_pkg::WORD_BITS'(1) << bit_q;
    free_bit    = low_clear(cur_word);
    cur_bit     = cur_word[bit_q];
    ram_we      = 1'b0;
    ram_wdata   = cur_word;
    status_next = 1'b1;
    taken_next  = 1'b0;
    alloc_next  = '0;
    hint_we     = 1'b0;
    if (state == ST_EXEC) begin
      case (cmd_q)
        bsa_pkg::CMD_ALLOC: begin
          if (found_q) begin
            ram_we      = 1'b1;
            ram_wdata   = cur_word | (bsa_pkg::WORD_BITS'(1) << free_bit);
            status_next = 1'b0;
            alloc_next  = {wi_q, free_bit};
            hint_we     = 1'b1;
          end
        end
        bsa_pkg::CMD_SET: begin
          if (in_range_q && !cur_bit) begin
            ram_we      = 1'b1;
            ram_wdata   = cur_word | bit_mask;
            status_next = 1'b0;
          end
        end
        bsa_pkg::CMD_RELEASE: begin
          if (in_range_q && cur_bit) begin
            ram_we      = 1'b1;
            ram_wdata   = cur_word & ~bit_mask;
            status_next = 1'b0;
            hint_we     = (wi_q < hint);
          end
        end
        bsa_pkg::CMD_PROBE: begin
          status_next = 1'b0;
          taken_next  = in_range_q && cur_bit;
        end
        default: begin
          status_next = 1'b1;
        end
      endcase
    end
  end

  // Sequencer, side state and registered result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      active_words <= bsa_pkg::ACT_WORDS_RESET;
      hint         <= '0;
      word_full    <= '0;
      word_valid   <= '0;
      done         <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_wr_en) begin
        active_words <= cfg_wr_data;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state      <= ST_EXEC;
            cmd_q      <= bsa_pkg::cmd_t'(cmd);
            wi_q       <= rd_wi;
            bit_q      <= in_bit;
            in_range_q <= in_range;
            found_q    <= |cand;
          end
        end
        ST_EXEC: begin
          state           <= ST_IDLE;
          done            <= 1'b1;
          status          <= status_next;
          allocated_index <= alloc_next;
          slot_taken      <= taken_next;
          if (ram_we) begin
            word_valid[wi_q] <= 1'b1;
            word_full[wi_q]  <= &ram_wdata;
          end
          if (hint_we) begin
            hint <= wi_q;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // Every accepted command produces its result after its modify step.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> ##1 done)
    else $error("result missing after accepted command");

  // The result word only appears once the core is free again.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");

  // The bitmap RAM is written only in the modify step.
  a_write_exec: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ST_EXEC))
    else $error("bitmap write outside modify step");

  // A successful allocate grants a slot inside the active range.
  a_alloc_range: assert property (@(posedge clk) disable iff (rst)
    (ram_we && (cmd_q == bsa_pkg::CMD_ALLOC)) |->
      ({1'b0, wi_q} < eff_words))
    else $error("allocate granted a word outside the active range");
`endif

endmodule

FILE: src/bsa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module bsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: tb/sv/bitmap_slot_allocator_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap slot allocator core testbench
// Drives allocate, set, release and probe command words with random gaps and
// reconfigures the active word count between phases. A behavioral copy of the
// slot bitmap and first-free hint predicts every result word, and each word
// that the core returns is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module bitmap_slot_allocator_core_tb;

  localparam int RESET_CYCLES = 10;
  localparam int MAX_GAP      = 8;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_WORDS  = 80;

  localparam logic ST_OK          = 1'b0;
  localparam logic ST_NO_INSTANCE = 1'b1;

  typedef struct packed {
    bsa_pkg::cmd_t                  op;
    logic [bsa_pkg::SLOT_IDX_W-1:0] index;
    logic                           status;
    logic [bsa_pkg::SLOT_IDX_W-1:0] granted;
    logic                           taken;
  } slot_result_t;

  logic                           clk;
  logic                           rst;
  logic                           start;
  logic                           busy;
  logic [bsa_pkg::CMD_W-1:0]      cmd;
  logic [bsa_pkg::SLOT_IDX_W-1:0] entry_index;
  logic                           cfg_wr_en;
  logic [bsa_pkg::ACT_W-1:0]      cfg_wr_data;
  logic                           done;
  logic                           status;
  logic [bsa_pkg::SLOT_IDX_W-1:0] allocated_index;
  logic                           slot_taken;

  // Predicted allocator state.
  logic [bsa_pkg::WORD_BITS-1:0]  slot_map [bsa_pkg::NUM_WORDS];
  logic [bsa_pkg::WORD_IDX_W-1:0] free_hint;
  logic [bsa_pkg::ACT_W-1:0]      active_words_cfg;

  slot_result_t pending_results [$];
  int           mismatches;
  int           cycle_count;
  int           burst_left;

  bitmap_slot_allocator_core uut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .cmd             (cmd),
    .entry_index     (entry_index),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .done            (done),
    .status          (status),
    .allocated_index (allocated_index),
    .slot_taken      (slot_taken)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Values above the bitmap size behave as the full bitmap.
  function automatic int effective_words();
    return (active_words_cfg > bsa_pkg::NUM_WORDS) ? bsa_pkg::NUM_WORDS :
           int'(active_words_cfg);
  endfunction

  // Applies one command word to the predicted state and returns its result.
  function automatic slot_result_t predict_command(
    bsa_pkg::cmd_t op,
    logic [bsa_pkg::SLOT_IDX_W-1:0] index
  );
    slot_result_t                  r;
    int                            words;
    int                            wi;
    int                            w;
    int                            bit_pos;
    logic [bsa_pkg::WORD_BITS-1:0] mask;
    logic                          in_range;
    logic                          found;
    r.op      = op;
    r.index   = index;
    r.status  = ST_NO_INSTANCE;
    r.granted = '0;
    r.taken   = 1'b0;
    words     = effective_words();
    wi        = int'(index >> bsa_pkg::BIT_IDX_W);
    mask      = bsa_pkg::WORD_BITS'(1) << index[bsa_pkg::BIT_IDX_W-1:0];
    in_range  = (wi < words);
    found     = 1'b0;
    case (op)
      bsa_pkg::CMD_ALLOC: begin
        // Scan upward from the hint without wrapping.
        for (w = int'(free_hint); w < words; w++) begin
          if (!found && slot_map[w] != '1) begin
            bit_pos = 0;
            while (bit_pos < bsa_pkg::WORD_BITS - 1 && slot_map[w][bit_pos]) bit_pos++;
            slot_map[w][bit_pos] = 1'b1;
            free_hint = bsa_pkg::WORD_IDX_W'(w);
            r.granted = bsa_pkg::SLOT_IDX_W'(w * bsa_pkg::WORD_BITS + bit_pos);
            r.status  = ST_OK;
            found     = 1'b1;
          end
        end
      end
      bsa_pkg::CMD_SET: begin
        if (in_range && (slot_map[wi] & mask) == '0) begin
          slot_map[wi] = slot_map[wi] | mask;
          r.status = ST_OK;
        end
      end
      bsa_pkg::CMD_RELEASE: begin
        if (in_range && (slot_map[wi] & mask) != '0) begin
          slot_map[wi] = slot_map[wi] & ~mask;
          if (wi < int'(free_hint)) free_hint = bsa_pkg::WORD_IDX_W'(wi);
          r.status = ST_OK;
        end
      end
      default: begin
        r.status = ST_OK;
        r.taken  = in_range && ((slot_map[wi] & mask) != '0);
      end
    endcase
    return r;
  endfunction

  // Sends one command word after a random gap, or none inside a burst.
  task automatic issue_command(bsa_pkg::cmd_t op, logic [bsa_pkg::SLOT_IDX_W-1:0] index);
    int gap;
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else if ($urandom_range(0, 15) == 0) begin
      gap = 0;
      burst_left = $urandom_range(5, 30);
    end else begin
      gap = $urandom_range(0, MAX_GAP);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    cmd         <= op;
    entry_index <= index;
    do @(posedge clk); while (busy !== 1'b0);
    pending_results.push_back(predict_command(op, index));
  endtask

  // Writes the active word count once the core has drained.
  task automatic write_active_words(logic [bsa_pkg::ACT_W-1:0] value);
    start <= 1'b0;
    while (pending_results.size() != 0 || busy !== 1'b0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    active_words_cfg = value;
  endtask

  // Mostly indices inside the active range; taken slots are preferred on request.
  function automatic logic [bsa_pkg::SLOT_IDX_W-1:0] pick_index(bit want_taken);
    int                             span;
    int                             tries;
    logic [bsa_pkg::SLOT_IDX_W-1:0] idx;
    span = effective_words() * bsa_pkg::WORD_BITS;
    if (span == 0 || $urandom_range(0, 6) == 0) return bsa_pkg::SLOT_IDX_W'($urandom);
    idx = bsa_pkg::SLOT_IDX_W'($urandom_range(0, span - 1));
    for (tries = 0; tries < 8 && want_taken &&
         !slot_map[idx >> bsa_pkg::BIT_IDX_W][idx[bsa_pkg::BIT_IDX_W-1:0]]; tries++) begin
      idx = bsa_pkg::SLOT_IDX_W'($urandom_range(0, span - 1));
    end
    return idx;
  endfunction

  task automatic test_reset_state();
    issue_command(bsa_pkg::CMD_PROBE, bsa_pkg::SLOT_IDX_W'(0));
    issue_command(bsa_pkg::CMD_PROBE, '1);
    issue_command(bsa_pkg::CMD_ALLOC, '1);
    issue_command(bsa_pkg::CMD_ALLOC, bsa_pkg::SLOT_IDX_W'(0));
    issue_command(bsa_pkg::CMD_PROBE, bsa_pkg::SLOT_IDX_W'(1));
  endtask

  task automatic test_set_release();
    issue_command(bsa_pkg::CMD_SET, '1);
    issue_command(bsa_pkg::CMD_SET, '1);
    issue_command(bsa_pkg::CMD_PROBE, '1);
    issue_command(bsa_pkg::CMD_RELEASE, '1);
    issue_command(bsa_pkg::CMD_RELEASE, '1);
    issue_command(bsa_pkg::CMD_RELEASE, bsa_pkg::SLOT_IDX_W'(0));
    issue_command(bsa_pkg::CMD_ALLOC, bsa_pkg::SLOT_IDX_W'(0));
    issue_command(bsa_pkg::CMD_SET, bsa_pkg::SLOT_IDX_W'(10'h2AA));
    issue_command(bsa_pkg::CMD_SET, bsa_pkg::SLOT_IDX_W'(10'h155));
    issue_command(bsa_pkg::CMD_PROBE, bsa_pkg::SLOT_IDX_W'(10'h2AA));
    issue_command(bsa_pkg::CMD_RELEASE, bsa_pkg::SLOT_IDX_W'(10'h155));
  endtask

  // Empty, oversized and single-word active sizes.
  task automatic test_range_limits();
    write_active_words(bsa_pkg::ACT_W'(0));
    issue_command(bsa_pkg::CMD_ALLOC, bsa_pkg::SLOT_IDX_W'(0));
    issue_command(bsa_pkg::CMD_SET, bsa_pkg::SLOT_IDX_W'(0));
    issue_command(bsa_pkg::CMD_RELEASE, bsa_pkg::SLOT_IDX_W'(0));
    issue_command(bsa_pkg::CMD_PROBE, bsa_pkg::SLOT_IDX_W'(0));
    write_active_words(bsa_pkg::ACT_W'(63));
    issue_command(bsa_pkg::CMD_SET, '1);
    issue_command(bsa_pkg::CMD_PROBE, '1);
    issue_command(bsa_pkg::CMD_RELEASE, '1);
    write_active_words(bsa_pkg::ACT_W'(1));
    issue_command(bsa_pkg::CMD_SET, bsa_pkg::SLOT_IDX_W'(32));
    issue_command(bsa_pkg::CMD_RELEASE, bsa_pkg::SLOT_IDX_W'(32));
    issue_command(bsa_pkg::CMD_PROBE, bsa_pkg::SLOT_IDX_W'(32));
    issue_command(bsa_pkg::CMD_SET, bsa_pkg::SLOT_IDX_W'(31));
    issue_command(bsa_pkg::CMD_PROBE, bsa_pkg::SLOT_IDX_W'(31));
  endtask

  // Fills two words so the hint moves up, then shrinks to one word.
  task automatic test_fill_and_shrink();
    write_active_words(bsa_pkg::ACT_W'(2));
    repeat (70) begin
      if ($urandom_range(0, 4) == 0) issue_command(bsa_pkg::CMD_PROBE, pick_index(1'b0));
      issue_command(bsa_pkg::CMD_ALLOC, bsa_pkg::SLOT_IDX_W'($urandom));
    end
    write_active_words(bsa_pkg::ACT_W'(1));
    issue_command(bsa_pkg::CMD_ALLOC, bsa_pkg::SLOT_IDX_W'($urandom));
    repeat (3) begin
      issue_command(bsa_pkg::CMD_RELEASE,
                    bsa_pkg::SLOT_IDX_W'($urandom_range(0, bsa_pkg::WORD_BITS - 1)));
    end
    repeat (4) issue_command(bsa_pkg::CMD_ALLOC, bsa_pkg::SLOT_IDX_W'($urandom));
  endtask

  task automatic run_traffic(int count, int alloc_pct);
    int roll;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < alloc_pct) begin
        issue_command(bsa_pkg::CMD_ALLOC, bsa_pkg::SLOT_IDX_W'($urandom));
      end else if (roll < alloc_pct + 20) begin
        issue_command(bsa_pkg::CMD_SET, pick_index(1'b0));
      end else if (roll < alloc_pct + 45) begin
        issue_command(bsa_pkg::CMD_RELEASE, pick_index(1'b1));
      end else begin
        issue_command(bsa_pkg::CMD_PROBE, pick_index(1'($urandom_range(0, 1))));
      end
    end
  endtask

  // Phases over several active sizes, the extremes among them.
  task automatic test_random_traffic();
    logic [bsa_pkg::ACT_W-1:0] sizes [9];
    sizes = '{bsa_pkg::ACT_W'(32), bsa_pkg::ACT_W'(1), bsa_pkg::ACT_W'(63),
              bsa_pkg::ACT_W'(3), bsa_pkg::ACT_W'(0), bsa_pkg::ACT_W'(2),
              bsa_pkg::ACT_W'(8), bsa_pkg::ACT_W'($urandom_range(0, 63)),
              bsa_pkg::ACT_W'(32)};
    foreach (sizes[i]) begin
      write_active_words(sizes[i]);
      run_traffic(PHASE_WORDS, $urandom_range(25, 55));
    end
  endtask

  // Compares each result word with the oldest prediction.
  always @(posedge clk) begin : check_results
    slot_result_t want;
    if (!rst && done !== 1'b0) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word: status %0b index %0d taken %0b",
                 $time, status, allocated_index, slot_taken);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status) begin
          $display("%0t: %s %0d status: expected %0b actual %0b",
                   $time, want.op.name(), want.index, want.status, status);
          mismatches++;
        end
        if (allocated_index !== want.granted) begin
          $display("%0t: %s %0d allocated_index: expected %0d actual %0d",
                   $time, want.op.name(), want.index, want.granted, allocated_index);
          mismatches++;
        end
        if (slot_taken !== want.taken) begin
          $display("%0t: %s %0d slot_taken: expected %0b actual %0b",
                   $time, want.op.name(), want.index, want.taken, slot_taken);
          mismatches++;
        end
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d result words outstanding",
               $time, pending_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst         <= 1'b1;
    start       <= 1'b0;
    cmd         <= bsa_pkg::CMD_ALLOC;
    entry_index <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    foreach (slot_map[i]) slot_map[i] = '0;
    free_hint        = '0;
    active_words_cfg = bsa_pkg::ACT_WORDS_RESET;
    mismatches       = 0;
    cycle_count      = 0;
    burst_left       = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_set_release();
    test_range_limits();
    test_fill_and_shrink();
    test_random_traffic();

    // Drain the last result words.
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
